### hw/rtl/v3n_pkg.sv
// Shared types and constants for the vector normalizer.
package v3n_pkg;

  localparam int unsigned CompW = 32;
  localparam int unsigned SumW  = 66;
  localparam int unsigned LenW  = 32;
  localparam int unsigned TolW  = 16;
  localparam int unsigned PassShift = 14;
  localparam int unsigned UnitShift = 30;
  localparam int unsigned NumComp = 3;
  localparam int unsigned DivQW = 31;  // quotient magnitude never exceeds 2^30

  // Work descriptor handed from the front to the back.
  typedef struct packed {
    logic [NumComp-1:0]            neg;
    logic [NumComp-1:0][CompW-1:0] mag;
    logic [SumW-1:0]               sum;
  } front_word_t;

  // One result word.
  typedef struct packed {
    logic                          degenerate;
    logic [LenW-1:0]               vec_length;
    logic [NumComp-1:0][CompW-1:0] unit;
  } result_word_t;

endpackage

### hw/rtl/v3n_front.sv
// Front: accepts vectors, takes magnitudes and forms the sum of squares in two stages.
module v3n_front
  import v3n_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NumComp-1:0][CompW-1:0] comp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output front_word_t                   out_word_o
);

  logic                          s1_valid_q, s2_valid_q;
  logic [NumComp-1:0]            s1_neg_q;
  logic [NumComp-1:0][CompW-1:0] s1_mag_q;
  logic [NumComp-1:0][2*CompW-1:0] sq_d;
  front_word_t                   s2_word_q;
  logic                          s2_en, s1_en;

  assign s2_en      = !s2_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      sq_d[i] = s1_mag_q[i] * s1_mag_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      for (int i = 0; i < NumComp; i++) begin
        s1_neg_q[i] <= comp_i[i][CompW-1];
        s1_mag_q[i] <= comp_i[i][CompW-1] ? (~comp_i[i] + 1'b1) : comp_i[i];
      end
    end
    if (s2_en && s1_valid_q) begin
      s2_word_q.neg <= s1_neg_q;
      s2_word_q.mag <= s1_mag_q;
      s2_word_q.sum <= SumW'(sq_d[0]) + SumW'(sq_d[1]) + SumW'(sq_d[2]);
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_word_o  = s2_word_q;

endmodule

### hw/rtl/v3n_fifo.sv
// Short queue between front and back.
module v3n_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == AW'(Depth-1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == AW'(Depth-1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_data_i;
  end

endmodule

### hw/rtl/v3n_back.sv
// Back: pipelined square root, tolerance check and three pipelined dividers.
module v3n_back
  import v3n_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TolW-1:0]   tol_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  front_word_t       in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_word_t      out_word_o
);

  localparam int unsigned RootSteps = LenW;      // one root bit per stage
  localparam int unsigned RemW      = LenW + 2;
  localparam int unsigned NumW      = CompW + UnitShift; // dividend bits

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- square root: restoring, one bit per stage ----------------
  logic                            r_valid_q [1:RootSteps];
  logic [SumW-1:0]                 r_sum_q   [1:RootSteps];
  logic [RemW-1:0]                 r_rem_q   [1:RootSteps];
  logic [LenW-1:0]                 r_root_q  [1:RootSteps];
  front_word_t                     r_word_q  [1:RootSteps];

  for (genvar s = 0; s < RootSteps; s++) begin : g_root
    logic            v_in;
    logic [SumW-1:0] sum_in;
    logic [RemW-1:0] rem_in, rem_sh, trial;
    logic [LenW-1:0] root_in;
    front_word_t     word_in;
    logic            ok;
    if (s == 0) begin : g_src
      assign v_in    = in_valid_i;
      assign sum_in  = in_word_i.sum;
      assign rem_in  = '0;
      assign root_in = '0;
      assign word_in = in_word_i;
    end else begin : g_src
      assign v_in    = r_valid_q[s];
      assign sum_in  = r_sum_q[s];
      assign rem_in  = r_rem_q[s];
      assign root_in = r_root_q[s];
      assign word_in = r_word_q[s];
    end
    always_comb begin
      rem_sh = {rem_in[RemW-3:0], sum_in[2*LenW-1 -: 2]};
      trial  = {root_in, 2'b01};
      ok     = rem_sh >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) r_valid_q[s+1] <= 1'b0;
      else if (en) r_valid_q[s+1] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        r_sum_q[s+1]  <= sum_in << 2;
        r_rem_q[s+1]  <= ok ? rem_sh - trial : rem_sh;
        r_root_q[s+1] <= {root_in[LenW-2:0], ok};
        r_word_q[s+1] <= word_in;
      end
    end
  end

  // ---------------- tolerance check ----------------
  logic [LenW-1:0] len;
  logic            degen;
  assign len   = r_root_q[RootSteps];
  assign degen = len <= LenW'(tol_i);

  // ---------------- division: restoring, one quotient bit per stage ----------
  logic                               d_valid_q [1:DivQW];
  logic [NumComp-1:0][NumW-1:0]       d_num_q   [1:DivQW];
  logic [NumComp-1:0][LenW:0]         d_rem_q   [1:DivQW];
  logic [NumComp-1:0][DivQW-1:0]      d_quo_q   [1:DivQW];
  logic [LenW-1:0]                    d_len_q   [1:DivQW];
  logic                               d_deg_q   [1:DivQW];
  front_word_t                        d_word_q  [1:DivQW];

  for (genvar s = 0; s < DivQW; s++) begin : g_div
    logic                          v_in, deg_in;
    logic [NumComp-1:0][NumW-1:0]  num_in;
    logic [NumComp-1:0][LenW:0]    rem_in;
    logic [NumComp-1:0][DivQW-1:0] quo_in;
    logic [LenW-1:0]               len_in;
    front_word_t                   word_in;
    logic [NumComp-1:0][LenW+1:0]  rsh;
    logic [NumComp-1:0]            ge;
    if (s == 0) begin : g_src
      assign v_in    = r_valid_q[RootSteps];
      assign deg_in  = degen;
      assign len_in  = len;
      assign word_in = r_word_q[RootSteps];
      assign quo_in  = '0;
      for (genvar i = 0; i < NumComp; i++) begin : g_comp
        // top bits of (mag << 30) beyond the quotient width fold into the remainder
        assign num_in[i] = {r_word_q[RootSteps].mag[i], UnitShift'(0)};
        assign rem_in[i] = (LenW+1)'(r_word_q[RootSteps].mag[i] >> (DivQW - UnitShift));
      end
    end else begin : g_src
      assign v_in    = d_valid_q[s];
      assign deg_in  = d_deg_q[s];
      assign len_in  = d_len_q[s];
      assign word_in = d_word_q[s];
      assign quo_in  = d_quo_q[s];
      assign num_in  = d_num_q[s];
      assign rem_in  = d_rem_q[s];
    end
    always_comb begin
      for (int i = 0; i < NumComp; i++) begin
        rsh[i] = {rem_in[i], num_in[i][DivQW-1-s]};
        ge[i]  = rsh[i] >= (LenW+2)'(len_in) && !deg_in;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d_valid_q[s+1] <= 1'b0;
      else if (en) d_valid_q[s+1] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < NumComp; i++) begin
          d_rem_q[s+1][i] <= (LenW+1)'(ge[i] ? rsh[i] - (LenW+2)'(len_in) : rsh[i]);
          d_quo_q[s+1][i] <= {quo_in[i][DivQW-2:0], ge[i]};
        end
        d_num_q[s+1]  <= num_in;
        d_len_q[s+1]  <= len_in;
        d_deg_q[s+1]  <= deg_in;
        d_word_q[s+1] <= word_in;
      end
    end
  end

  // ---------------- sign and output register ----------------
  result_word_t res_d, res_q;
  logic         ov_q;

  always_comb begin
    logic [CompW-1:0] m;
    res_d.vec_length = d_len_q[DivQW];
    res_d.degenerate = d_deg_q[DivQW];
    for (int i = 0; i < NumComp; i++) begin
      m = d_deg_q[DivQW] ? (d_word_q[DivQW].mag[i] << PassShift)
                         : CompW'(d_quo_q[DivQW][i]);
      res_d.unit[i] = d_word_q[DivQW].neg[i] ? (~m + 1'b1) : m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= d_valid_q[DivQW];
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = res_q;

endmodule

### hw/rtl/vector3_normalize.sv
// Top level of the 3D vector normalizer.
//
// Usage:
//  - s_axis: one vector per word; tdata holds comp_x, comp_y, comp_z
//    (signed Q16.16) from the lowest bit up.
//  - m_axis: one result per word; tdata holds unit_x, unit_y, unit_z
//    (signed Q2.30), vec_length (unsigned Q16.16); tuser is degenerate.
//  - cfg: valid/ready write of zero_tolerance (unsigned Q0.16, 16 bits); write it
//    only while the block is idle. Reset value is 1.
// Throughput: one vector per clock while m_axis_tready does not hold the output back.
// Pipeline: from the accepting edge to m_axis_tvalid a word passes the second
//   front stage (sum of squares), the queue, 32 stages of the bit-serial square
//   root, 31 stages of the three restoring dividers and the output
//   register.
// Stalls: the front keeps taking words while the queue has room; the back
//   pipeline freezes as a whole while its output word waits on tready.
// Reset: all valids clear, the queue empties, the tolerance returns to 1.
module vector3_normalize
  import v3n_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // comp_x, comp_y, comp_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // unit_x, unit_y, unit_z, vec_length
  output logic [0:0]   m_axis_tuser,   // degenerate
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  logic [TolW-1:0]               tol_q;
  logic [NumComp-1:0][CompW-1:0] comp;
  logic                          f_valid, f_ready, b_valid, b_ready;
  front_word_t                   f_word, b_word;
  result_word_t                  res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tol_q <= TolW'(1);
    else if (cfg_valid_i) tol_q <= cfg_data_i;
  end

  // pack order: comp_x in low bits
  assign comp[0] = s_axis_tdata[31:0];
  assign comp[1] = s_axis_tdata[63:32];
  assign comp[2] = s_axis_tdata[95:64];

  v3n_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready), .comp_i (comp),
    .out_valid_o (f_valid), .out_ready_i (f_ready), .out_word_o (f_word)
  );

  v3n_fifo #(.Width($bits(front_word_t)), .Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i (f_valid), .in_ready_o (f_ready), .in_data_i (f_word),
    .out_valid_o (b_valid), .out_ready_i (b_ready), .out_data_o (b_word)
  );

  v3n_back u_back (
    .clk_i, .rst_ni, .tol_i (tol_q),
    .in_valid_i (b_valid), .in_ready_o (b_ready), .in_word_i (b_word),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready), .out_word_o (res)
  );

  assign m_axis_tdata = {res.vec_length, res.unit[2], res.unit[1], res.unit[0]};
  assign m_axis_tuser = res.degenerate;

endmodule

### hw/rtl/v3n_checker.sv
// Port-level checker for the vector normalizer, bound to the top level.
module v3n_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         cfg_ready_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tdata[31:30] == 2'b00 || m_axis_tdata[31:30] == 2'b11 ||
       m_axis_tdata[31:0] == 32'h4000_0000))
    else $error("unit_x out of range");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[127:96] != 32'd0)
    else $error("zero length not flagged degenerate");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
  .cfg_ready_o
);

### tb/tb.sv
// Self-checking testbench for the 3D vector normalizer.
module tb;
  import v3n_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // comp_x, comp_y, comp_z
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // unit_x, unit_y, unit_z, vec_length
  logic [0:0]   m_axis_tuser;        // degenerate
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  typedef struct packed {
    logic        degen;
    logic [31:0] len;
    logic [31:0] uz, uy, ux;
  } norm_res_t;

  norm_res_t    expected_q[$];
  logic [15:0]  tol_shadow;
  int           errors = 0;
  int           cycles = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_cycles = 0;
  localparam int Limit = 2000000;

  always #4 clk_i = ~clk_i;

  vector3_normalize u_top (.*);

  function automatic logic [31:0] sqrt_floor(logic [65:0] n);
    logic [65:0] root, bitv;
    root = '0;
    bitv = 66'd1 << 64;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic norm_res_t normalize(logic [95:0] v);
    norm_res_t r;
    logic [31:0] mag [3];
    logic        neg [3];
    logic [65:0] sum;
    logic [63:0] m;
    logic [31:0] u [3];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[32*i+31];
      mag[i] = neg[i] ? 32'(-v[32*i +: 32]) : v[32*i +: 32];
      sum = sum + 66'(64'(mag[i]) * 64'(mag[i]));
    end
    r.len = sqrt_floor(sum);
    r.degen = (r.len <= {16'd0, tol_shadow});
    for (int i = 0; i < 3; i++) begin
      if (r.degen || r.len == 0) m = 64'(mag[i]) << 14;
      else m = (64'(mag[i]) << 30) / 64'(r.len);
      u[i] = neg[i] ? 32'(-m[31:0]) : m[31:0];
    end
    r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
    return r;
  endfunction

  // tvalid stays high across back-to-back words; it drops only for idle gaps
  task automatic send_vector(logic [31:0] x, y, z);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    expected_q.insert(expected_q.size(), normalize({z, y, x}));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_tol(logic [15:0] t);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= t;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tol_shadow = t;
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    norm_res_t got, exp_r;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, got);
        errors <= errors + 1;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_r, got);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp(int sz);
    logic [31:0] v;
    case (sz)
      0: v = $urandom_range(3);
      1: v = $urandom_range(255);
      2: v = $urandom_range(70000);
      default: v = $urandom;
    endcase
    if (sz < 3 && $urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic test_directed;
    send_vector(0, 0, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 0, 0);
    send_vector(0, 32'h7fff_ffff, 0);
    send_vector(0, 0, 32'hffff_ffff);
    send_vector(1, 0, 0);
    send_vector(2, 0, 0);
    send_vector(32'h0001_0000, 0, 0);
    send_vector(32'hffff_0000, 32'h0001_0000, 32'h0001_0000);
    send_vector(3, 4, 0);
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
  endtask

  task automatic test_tolerance_sweep;
    logic [15:0] tols [4] = '{16'd0, 16'hffff, 16'd300, 16'd1};
    foreach (tols[k]) begin
      write_tol(tols[k]);
      send_vector(0, 0, 0);
      send_vector(32'(tols[k]), 0, 0);
      send_vector(32'(tols[k]) + 1, 0, 0);
      send_vector(-32'(tols[k]), 1, 0);
      for (int i = 0; i < 30; i++) send_vector(rand_comp(1), rand_comp(1), rand_comp(0));
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_vector(rand_comp($urandom_range(3)), rand_comp($urandom_range(3)),
                  rand_comp($urandom_range(3)));
  endtask

  // more words than the pipeline and queue hold, so the input stalls
  task automatic test_backpressure;
    hold_cycles = 300;
    for (int i = 0; i < 100; i++) send_vector($urandom, $urandom, $urandom);
    drain();
    for (int i = 0; i < 10; i++) send_vector(rand_comp(2), rand_comp(2), rand_comp(2));
  endtask

  initial begin
    tol_shadow = 16'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    tx_idle_pct = 6;  rx_idle_pct = 85;
    test_random(80);
    test_tolerance_sweep();
    tx_idle_pct = 85; rx_idle_pct = 6;
    write_tol(16'd40);
    test_random(60);
    tx_idle_pct = 0;  rx_idle_pct = 0;
    test_random(60);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/v3n_pkg.sv
hw/rtl/v3n_front.sv
hw/rtl/v3n_fifo.sv
hw/rtl/v3n_back.sv
hw/rtl/vector3_normalize.sv
hw/rtl/v3n_checker.sv
tb/tb.sv
